// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the console writer.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("tcw assertion failed");

// Check that an expression never holds outside reset.
`define TCW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("tcw forbidden condition seen");

`endif

// ===== rtl/tcw_pkg.sv =====
// Package of the text console writer: transaction types, codes, defaults.
// Used by tcw_ctrl, text_console_writer and tcw_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 24;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_PUT  = 2'd0,
    KIND_BKSP = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECIDE,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] character;
    logic [4:0] row;
    logic [6:0] col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       scrolled;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1920
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcw_ctrl.sv =====
// Sequencer of the console writer: cursor, item decode, clearing pass and
// scroll sweep over the character RAM. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int CELLS  = ROWS * COLUMNS,
  localparam int AW     = $clog2(CELLS)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire in_item_t    in_item_i,
  output logic             in_stall_o,
  input  wire logic        res_ready_i,
  output logic             res_valid_o,
  output out_item_t        res_item_o,
  output logic             ram_we_o,
  output logic [AW-1:0]    ram_waddr_o,
  output logic [7:0]       ram_wdata_o,
  output logic             ram_re_o,
  output logic [AW-1:0]    ram_raddr_o,
  input  wire logic [7:0]  ram_rdata_i
);

  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS + 1);
  localparam int COPY_N = CELLS - COLUMNS;

  state_e          state_q, state_d;
  in_item_t        item_q, item_d;
  logic [RW-1:0]   crow_q, crow_d;
  logic [CW-1:0]   ccol_q, ccol_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic            scr_q, scr_d;
  logic            rdok_q, rdok_d;
  logic            wpend_q, wpend_d;
  logic            wsrc_q, wsrc_d;
  logic [AW-1:0]   waddr_q, waddr_d;

  logic            in_acc;
  logic            sweep_last;
  logic            put_nul, put_pend, put_eol, col_last, rd_ok;
  logic [RW-1:0]   bs_row;
  logic [CW-1:0]   bs_col;
  logic [AW-1:0]   cur_addr, bs_addr, rd_addr;

  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign sweep_last = (cnt_q == AW'(CELLS - 1));

  assign put_nul  = (item_q.character == CHAR_NUL);
  assign put_pend = (int'(crow_q) >= ROWS);
  assign put_eol  = (item_q.character == CHAR_LF) || (item_q.character == CHAR_CR);
  assign col_last = (ccol_q == CW'(COLUMNS - 1));
  assign rd_ok    = (int'(item_q.row) < ROWS) && (int'(item_q.col) < COLUMNS);

  // Backspace target: step left, or to the last column of the row above; stays at row 0, column 0.
  always_comb begin
    bs_row = crow_q;
    bs_col = ccol_q;
    if (ccol_q != '0) begin
      bs_col = ccol_q - CW'(1);
    end else if (crow_q != '0) begin
      bs_row = crow_q - RW'(1);
      bs_col = CW'(COLUMNS - 1);
    end
  end

  assign cur_addr = AW'(int'(crow_q) * COLUMNS + int'(ccol_q));
  assign bs_addr  = AW'(int'(bs_row) * COLUMNS + int'(bs_col));
  assign rd_addr  = AW'(int'(item_q.row) * COLUMNS + int'(item_q.col));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (item_q.kind == KIND_PUT && !put_nul && put_pend) begin
          state_d = ST_SCROLL;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SCROLL: begin
        if (sweep_last) state_d = ST_SCROLL_END;
      end
      ST_SCROLL_END: state_d = ST_DECIDE;
      ST_RESP: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    item_d      = item_q;
    crow_d      = crow_q;
    ccol_d      = ccol_q;
    cnt_d       = cnt_q;
    scr_d       = scr_q;
    rdok_d      = rdok_q;
    wpend_d     = 1'b0;
    wsrc_d      = wsrc_q;
    waddr_d     = waddr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_addr;
    ram_wdata_o = CHAR_NUL;
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_addr;
    res_valid_o = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);

    // Drain the write trailing the scroll reads.
    if (wpend_q) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = waddr_q;
      ram_wdata_o = wsrc_q ? ram_rdata_i : CHAR_NUL;
    end

    case (state_q)
      ST_INIT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q;
        ram_wdata_o = CHAR_SPACE;
        cnt_d       = sweep_last ? '0 : cnt_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          item_d = in_item_i;
          scr_d  = 1'b0;
          rdok_d = 1'b0;
        end
      end
      ST_DECIDE: begin
        case (kind_e'(item_q.kind))
          KIND_PUT: begin
            if (!put_nul) begin
              if (put_pend) begin
                scr_d = 1'b1;
                cnt_d = '0;
              end else if (put_eol) begin
                crow_d = crow_q + RW'(1);
                ccol_d = '0;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = cur_addr;
                ram_wdata_o = item_q.character;
                if (col_last) begin
                  ccol_d = '0;
                  crow_d = crow_q + RW'(1);
                end else begin
                  ccol_d = ccol_q + CW'(1);
                end
              end
            end
          end
          KIND_BKSP: begin
            ram_we_o    = 1'b1;
            ram_waddr_o = bs_addr;
            ram_wdata_o = CHAR_NUL;
            crow_d      = bs_row;
            ccol_d      = bs_col;
          end
          KIND_READ: begin
            ram_re_o = rd_ok;
            rdok_d   = rd_ok;
          end
          default: ;
        endcase
      end
      ST_SCROLL: begin
        // Read the cell one row below and write it to this cell in the next cycle; the last row is filled with NUL.
        ram_re_o    = (int'(cnt_q) < COPY_N);
        ram_raddr_o = AW'(int'(cnt_q) + COLUMNS);
        wpend_d     = 1'b1;
        wsrc_d      = (int'(cnt_q) < COPY_N);
        waddr_d     = cnt_q;
        cnt_d       = sweep_last ? '0 : cnt_q + AW'(1);
      end
      ST_SCROLL_END: begin
        crow_d = RW'(ROWS - 1);
        ccol_d = '0;
      end
      ST_RESP: begin
        res_valid_o = res_ready_i;
      end
      default: ;
    endcase
  end

  assign res_item_o.read_char  = rdok_q ? ram_rdata_i : CHAR_NUL;
  assign res_item_o.cursor_row = 5'(crow_q);
  assign res_item_o.cursor_col = 7'(ccol_q);
  assign res_item_o.scrolled   = scr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      crow_q  <= '0;
      ccol_q  <= '0;
      cnt_q   <= '0;
      scr_q   <= 1'b0;
      rdok_q  <= 1'b0;
      wpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      crow_q  <= crow_d;
      ccol_q  <= ccol_d;
      cnt_q   <= cnt_d;
      scr_q   <= scr_d;
      rdok_q  <= rdok_d;
      wpend_q <= wpend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    wsrc_q  <= wsrc_d;
    waddr_q <= waddr_d;
  end

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Text console writer: an item is taken in idle and decoded; the result
// register loads once it is free. No new item is taken until then. A put
// that scrolls first sweeps every cell through the RAM ports. After reset a
// clearing pass writes spaces to all ROWS*COLUMNS cells (1920 at default
// size) with in_stall_o high; cursor and handshake state reset at once.
// Holds the output register; depends on tcw_pkg, tcw_ctrl and tcw_ram.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_item_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic            res_ready, res_valid;
  out_item_t       res_item;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q;

  assign res_ready = !out_valid_q || !out_stall_i;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_item_o  (res_item),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold the result until the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_valid) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_item_q <= res_item;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
// Port-level checker of the text console writer and its bind statement.
// Depends on tcw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  `TCW_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
  `TCW_ASSERT_NEVER(a_col_range, clk_i, rst_ni, out_valid_o && int'(out_item_o.cursor_col) >= COLUMNS)
  `TCW_ASSERT(a_pend_col0, clk_i, rst_ni, out_valid_o && int'(out_item_o.cursor_row) == ROWS |-> out_item_o.cursor_col == 7'd0)
  `TCW_ASSERT(a_scroll_row, clk_i, rst_ni, out_valid_o && out_item_o.scrolled && (ROWS < 32) |-> int'(out_item_o.cursor_row) == ROWS - 1 || int'(out_item_o.cursor_row) == ROWS)
  `TCW_ASSERT(a_stall_busy, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
